// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;

  // operation codes on the input channel
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_TRV = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ENQ   = 3'd0;
  localparam logic [2:0] ST_DEQ   = 3'd1;
  localparam logic [2:0] ST_OVF   = 3'd2;
  localparam logic [2:0] ST_UNF   = 3'd3;
  localparam logic [2:0] ST_TRV   = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  // per-cycle command broadcast to every cell
  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEQ  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    entry_t     item;
  } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and trades it with neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,   // slot index below current count
  input  logic      is_tail,    // slot holds the last stored entry
  input  logic      left_keep,  // left neighbor keeps its entry on insert
  input  entry_t    left_q,
  input  entry_t    right_q,
  input  entry_t    head_q,
  output logic      keep,
  output entry_t    q
);

  entry_t data_r;
  entry_t data_nxt;

  // ties stay ahead of the new entry, so <= keeps arrival order
  assign keep = occupied && ($signed(data_r.prio) <= $signed(ctl.item.prio));
  assign q    = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctl.kind)
      CMD_INS: begin
        if (!keep) begin
          data_nxt = left_keep ? ctl.item : left_q;
        end
      end
      CMD_DEQ: data_nxt = right_q;
      CMD_ROT: data_nxt = is_tail ? head_q : right_q;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: enqueue/dequeue, traverse one word per cycle unless stalled.
// Enqueue, dequeue and error results appear the cycle after accept.
// One enqueue/dequeue per cycle if not stalled; traverse holds input to its last word.
// Each cycle the cell chain holds, shifts, inserts or rotates by one slot in parallel.
// Reset (rst_n, sync, active low) empties the queue; no clearing pass is needed.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue import spq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic signed [PRI_W-1:0] in_item_priority,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_status,
  output logic signed [VAL_W-1:0] out_value,
  output logic signed [PRI_W-1:0] out_priority,
  output logic                    out_last
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             trv_busy_r, trv_busy_nxt;
  logic [IDX_W-1:0] trv_idx_r, trv_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  entry_t           out_item_r, out_item_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t ctl;
  entry_t    cell_q    [CAPACITY];
  entry_t    left_q    [CAPACITY];
  entry_t    right_q   [CAPACITY];
  logic      keep      [CAPACITY];
  logic      left_keep [CAPACITY];

  logic out_free;
  logic in_acc;
  logic full;
  logic empty;
  logic trv_last;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !trv_busy_r && out_free;
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign trv_last = ((CNT_W'(trv_idx_r) + CNT_W'(1)) == count_r);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_q[i]    = cell_q[i];
        assign left_keep[i] = 1'b1;
      end else begin : g_mid
        assign left_q[i]    = cell_q[i-1];
        assign left_keep[i] = keep[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
        assign right_q[i] = cell_q[i];
      end else begin : g_inner
        assign right_q[i] = cell_q[i+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (CNT_W'(i) < count_r),
        .is_tail   (count_r == CNT_W'(i + 1)),
        .left_keep (left_keep[i]),
        .left_q    (left_q[i]),
        .right_q   (right_q[i]),
        .head_q    (cell_q[0]),
        .keep      (keep[i]),
        .q         (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    ctl.kind       = CMD_HOLD;
    ctl.item.value = in_item_value;
    ctl.item.prio  = in_item_priority;
    count_nxt      = count_r;
    trv_busy_nxt   = trv_busy_r;
    trv_idx_nxt    = trv_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;

    if (trv_busy_r) begin
      if (out_free) begin
        ctl.kind       = CMD_ROT;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_TRV;
        out_item_nxt   = cell_q[0];
        out_last_nxt   = trv_last;
        trv_idx_nxt    = trv_idx_r + IDX_W'(1);
        if (trv_last) begin
          trv_busy_nxt = 1'b0;
        end
      end
    end else if (in_acc) begin
      out_item_nxt = '0;
      out_last_nxt = 1'b1;
      case (in_operation)
        OP_ENQ: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_status_nxt = ST_OVF;
          end else begin
            ctl.kind       = CMD_INS;
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = ST_ENQ;
          end
        end
        OP_DEQ: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_status_nxt = ST_UNF;
          end else begin
            ctl.kind       = CMD_DEQ;
            count_nxt      = count_r - CNT_W'(1);
            out_status_nxt = ST_DEQ;
            out_item_nxt   = cell_q[0];
          end
        end
        OP_TRV: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            // first word goes out now; rest rotate through the head
            ctl.kind       = CMD_ROT;
            out_status_nxt = ST_TRV;
            out_item_nxt   = cell_q[0];
            out_last_nxt   = (count_r == CNT_W'(1));
            trv_busy_nxt   = (count_r != CNT_W'(1));
            trv_idx_nxt    = IDX_W'(1);
          end
        end
        default: begin
          // unused code: no word, no state change
          out_valid_nxt = out_valid_r && !out_ready;
          out_item_nxt  = out_item_r;
          out_last_nxt  = out_last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      trv_busy_r  <= 1'b0;
      trv_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      trv_busy_r  <= trv_busy_nxt;
      trv_idx_r   <= trv_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = out_item_r.value;
  assign out_priority = out_item_r.prio;
  assign out_last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_trv_idx: assert property (@(posedge clk) disable iff (!rst_n)
    trv_busy_r |-> (CNT_W'(trv_idx_r) < count_r))
    else $error("traverse index past tail");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_ENQ && !full) |=>
      (count_r == $past(count_r) + CNT_W'(1)) && out_valid_r && out_status_r == ST_ENQ)
    else $error("enqueue did not grow the queue");

  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_DEQ && !empty) |=>
      out_valid_r && out_status_r == ST_DEQ && out_item_r == $past(cell_q[0]))
    else $error("dequeue did not return the head");

  a_trv_end: assert property (@(posedge clk) disable iff (!rst_n)
    (trv_busy_r && out_free && trv_last) |=> !trv_busy_r && out_last_r)
    else $error("traverse did not finish on the tail");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sorted_priority_queue: directed words, then random
// traffic under several idle/stall mixes, checked against a predictor in a scoreboard.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb import spq_pkg::*; ();

  localparam logic [1:0] OP_NONE = 2'd3;  // unused code, block ignores it
  localparam int LIMIT_CYCLES = 300000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
    logic                    last;
  } pq_result_t;

  class pq_scoreboard;
    logic signed [VAL_W-1:0] held_value [CAPACITY];
    logic signed [PRI_W-1:0] held_prio  [CAPACITY];
    int held_count;
    pq_result_t predicted[$];
    int n_errors, n_checked, n_words, n_ignored, longest_walk;
    int n_status [8];

    function new();
      held_count   = 0;
      n_errors     = 0;
      n_checked    = 0;
      n_words      = 0;
      n_ignored    = 0;
      longest_walk = 0;
      foreach (n_status[k]) n_status[k] = 0;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void add_result(logic [2:0] st, logic signed [VAL_W-1:0] v,
                             logic signed [PRI_W-1:0] p, logic lst);
      pq_result_t r;
      r.status = st;
      r.value  = v;
      r.prio   = p;
      r.last   = lst;
      predicted.push_back(r);
      n_status[st]++;
    endfunction

    // advance the predicted queue state by one accepted input word
    function void note_word(logic [1:0] op, logic signed [VAL_W-1:0] v,
                            logic signed [PRI_W-1:0] p);
      int pos;
      int i;
      if (op == OP_NONE) begin
        n_ignored++;
        return;
      end
      n_words++;
      case (op)
        OP_ENQ: begin
          if (held_count >= CAPACITY) begin
            add_result(ST_OVF, '0, '0, 1'b1);
          end else begin
            // equal priorities go behind the ones already stored
            pos = 0;
            while (pos < held_count && held_prio[pos] <= p) pos++;
            for (i = held_count; i > pos; i--) begin
              held_value[i] = held_value[i-1];
              held_prio[i]  = held_prio[i-1];
            end
            held_value[pos] = v;
            held_prio[pos]  = p;
            held_count++;
            add_result(ST_ENQ, '0, '0, 1'b1);
          end
        end
        OP_DEQ: begin
          if (held_count == 0) begin
            add_result(ST_UNF, '0, '0, 1'b1);
          end else begin
            add_result(ST_DEQ, held_value[0], held_prio[0], 1'b1);
            for (i = 1; i < held_count; i++) begin
              held_value[i-1] = held_value[i];
              held_prio[i-1]  = held_prio[i];
            end
            held_count--;
          end
        end
        OP_TRV: begin
          if (held_count == 0) begin
            add_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (i = 0; i < held_count; i++)
              add_result(ST_TRV, held_value[i], held_prio[i], i == held_count - 1);
            if (held_count > longest_walk) longest_walk = held_count;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [2:0] st, logic signed [VAL_W-1:0] v,
                             logic signed [PRI_W-1:0] p, logic lst);
      pq_result_t e;
      if (predicted.size() == 0) begin
        $error("result word with nothing pending: status %0d value %0d priority %0d",
               st, v, p);
        n_errors++;
        return;
      end
      e = predicted.pop_front();
      n_checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        n_errors++;
      end
      if (v !== e.value) begin
        $error("out_value: expected %0d, got %0d", e.value, v);
        n_errors++;
      end
      if (p !== e.prio) begin
        $error("out_priority: expected %0d, got %0d", e.prio, p);
        n_errors++;
      end
      if (lst !== e.last) begin
        $error("out_last: expected %0d, got %0d", e.last, lst);
        n_errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_operation;
  logic signed [VAL_W-1:0] in_item_value;
  logic signed [PRI_W-1:0] in_item_priority;
  logic                    out_valid;
  logic                    out_ready;
  logic [2:0]              out_status;
  logic signed [VAL_W-1:0] out_value;
  logic signed [PRI_W-1:0] out_priority;
  logic                    out_last;

  pq_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold;

  sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", LIMIT_CYCLES,
             sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  // result side: check accepted words, then pick next cycle's ready
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(out_status, out_value, out_priority, out_last);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [VAL_W-1:0] v,
                           input logic signed [PRI_W-1:0] p);
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_item_value    <= v;
    in_item_priority <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, v, p);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop offering and wait for the block to empty its result pipe
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [PRI_W-1:0] pick_prio();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return PRI_W'($signed($urandom_range(8)) - 4);  // dense ties
    if (sel < 8) return PRI_W'($urandom);
    if (sel == 8) return {1'b1, {(PRI_W-1){1'b0}}};
    return {1'b0, {(PRI_W-1){1'b1}}};
  endfunction

  // n_words real operations; enq_pct < 0 re-rolls the fill bias every 40 words
  task automatic random_words(input int n_words, input int enq_pct);
    int done;
    int bias;
    int r;
    logic [1:0] op;
    done = 0;
    bias = enq_pct;
    while (done < n_words) begin
      if (enq_pct < 0 && done % 40 == 0) begin
        case ($urandom_range(2))
          0: bias = 25;
          1: bias = 50;
          default: bias = 80;
        endcase
      end
      r = $urandom_range(99);
      if (r < 2) op = OP_NONE;
      else if (r < 12) op = OP_TRV;
      else if ($urandom_range(99) < bias) op = OP_ENQ;
      else op = OP_DEQ;
      send_word(op, VAL_W'($urandom), pick_prio());
      if (op != OP_NONE) done++;
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input int n_words);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    random_words(n_words, -1);
    drain();
  endtask

  initial begin
    int i;
    sb           = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_ENQ;
    in_item_value    <= '0;
    in_item_priority <= '0;
    out_ready        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, head insert, ties, full queue
    send_word(OP_DEQ, 32'sd5, 16'sd5);
    send_word(OP_TRV, '0, '0);
    send_word(OP_NONE, 32'sd9, 16'sd9);
    send_word(OP_ENQ, {1'b0, {(VAL_W-1){1'b1}}}, 16'sd0);
    send_word(OP_ENQ, {1'b1, {(VAL_W-1){1'b0}}}, {1'b1, {(PRI_W-1){1'b0}}});
    send_word(OP_ENQ, -32'sd1, {1'b0, {(PRI_W-1){1'b1}}});
    send_word(OP_ENQ, 32'sd0, 16'sd0);
    send_word(OP_TRV, '0, '0);
    for (i = 0; i < CAPACITY - 4; i++)
      send_word(OP_ENQ, VAL_W'($urandom), PRI_W'($signed($urandom_range(20)) - 10));
    send_word(OP_ENQ, 32'sd77, -16'sd1);
    send_word(OP_TRV, '0, '0);
    for (i = 0; i < 3; i++)
      send_word(OP_DEQ, '0, '0);
    drain();

    // no idling, then a long receiver hold while the sender keeps pushing
    run_phase(0, 0, 70);
    rx_hold = 150;
    random_words(30, 80);
    drain();

    run_phase(60, 0, 100);
    run_phase(0, 60, 100);
    run_phase(36, 36, 100);

    $display("%0d words sent (%0d ignored), %0d results checked, longest traverse %0d",
             sb.n_words, sb.n_ignored, sb.n_checked, sb.longest_walk);
    $display("overflow %0d, underflow %0d, traverse-empty %0d, dequeued %0d",
             sb.n_status[ST_OVF], sb.n_status[ST_UNF], sb.n_status[ST_EMPTY],
             sb.n_status[ST_DEQ]);
    if (sb.n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
